// File: rtl/broadcast_index_to_offset_top_defines.svh
// ----------------------------------------------------------------------------
// Broadcast index to offset: assertion macros
// Shared property wrappers, clocked on aclk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BROADCAST_INDEX_TO_OFFSET_TOP_DEFINES_SVH
`define BROADCAST_INDEX_TO_OFFSET_TOP_DEFINES_SVH

// same-cycle implication
`define BITO_AST_IMM(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BITO_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bito_pkg.sv
// ----------------------------------------------------------------------------
// bito_pkg
// Widths, types and the restoring-division step shared by the address path.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bito_pkg;

    localparam int RANK    = 4;
    localparam int IDX_W   = 32;
    localparam int DIM_W   = 16;
    localparam int OFF_W   = 35;
    localparam int EB_W    = 4;
    localparam int TDATA_W = ((RANK * DIM_W + OFF_W + 7) / 8) * 8;
    localparam int PAD_W   = TDATA_W - RANK * DIM_W - OFF_W;
    localparam int ADDR_W  = 5;

    typedef logic [RANK-1:0][DIM_W-1:0] crd_vec_t;

    typedef enum logic [2:0] {
        REG_SIZE0  = 3'd0,
        REG_SIZE1  = 3'd1,
        REG_SIZE2  = 3'd2,
        REG_SIZE3  = 3'd3,
        REG_BMASK  = 3'd4,
        REG_EBYTES = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] num;
    } div_st_t;

    typedef struct packed {
        logic [OFF_W-1:0] off;
        crd_vec_t         crd;
    } out_word_t;

    // one quotient bit: shift the next dividend bit into the remainder
    function automatic div_st_t div_step(input div_st_t cur, input logic [DIM_W-1:0] dvsr);
        logic [DIM_W:0] trial;
        logic           ge;
        div_st_t        nxt;
        trial       = {cur.rem, cur.num[IDX_W-1]};
        ge          = (trial >= {1'b0, dvsr});
        nxt.num     = {cur.num[IDX_W-2:0], ge};
        nxt.rem     = ge ? DIM_W'(trial - {1'b0, dvsr}) : trial[DIM_W-1:0];
        return nxt;
    endfunction

endpackage

`default_nettype wire

// File: rtl/bito_div_unit.sv
// ----------------------------------------------------------------------------
// bito_div_unit
// Pipelined restoring divider, one quotient bit per stage, coords ride along.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bito_div_unit (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_vld,
    input  wire logic [bito_pkg::IDX_W-1:0]   in_num,
    input  wire bito_pkg::crd_vec_t           in_crd,
    input  wire logic [bito_pkg::DIM_W-1:0]   dvsr,
    output logic                              out_vld,
    output logic [bito_pkg::IDX_W-1:0]        out_quo,
    output logic [bito_pkg::DIM_W-1:0]        out_rem,
    output bito_pkg::crd_vec_t                out_crd
);

    localparam int N = bito_pkg::IDX_W;

    logic [bito_pkg::DIM_W-1:0] dv;
    logic [N-1:0]               vld_reg, vld_next;
    bito_pkg::div_st_t          st_reg  [N];
    bito_pkg::div_st_t          st_next [N];
    bito_pkg::crd_vec_t         crd_reg [N];
    bito_pkg::crd_vec_t         crd_next[N];
    bito_pkg::div_st_t          src;

    // size 0 behaves as size 1
    assign dv = (dvsr == '0) ? bito_pkg::DIM_W'(1) : dvsr;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                src.rem     = '0;
                src.num     = in_num;
                vld_next[k] = in_vld;
                crd_next[k] = in_crd;
            end else begin
                src         = st_reg[k-1];
                vld_next[k] = vld_reg[k-1];
                crd_next[k] = crd_reg[k-1];
            end
            st_next[k] = bito_pkg::div_step(src, dv);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                st_reg[k]  <= st_next[k];
                crd_reg[k] <= crd_next[k];
            end
        end
    end

    assign out_vld = vld_reg[N-1];
    assign out_quo = st_reg[N-1].num;
    assign out_rem = st_reg[N-1].rem;
    assign out_crd = crd_reg[N-1];

endmodule

`default_nettype wire

// File: rtl/bito_ravel.sv
// ----------------------------------------------------------------------------
// bito_ravel
// Coordinates to byte offset: stride products, sum, element-size scale.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bito_ravel (
    input  wire logic                                           aclk,
    input  wire logic                                           aresetn,
    input  wire logic                                           en,
    input  wire logic                                           in_vld,
    input  wire bito_pkg::crd_vec_t                             in_crd,
    input  wire logic [bito_pkg::RANK-1:0][bito_pkg::DIM_W-1:0] sizes,
    input  wire logic [bito_pkg::RANK-1:0]                      bmask,
    input  wire logic [bito_pkg::EB_W-1:0]                      ebytes,
    output logic                                                out_vld,
    output bito_pkg::out_word_t                                 out_word
);

    localparam int OW = bito_pkg::OFF_W;
    localparam int DW = bito_pkg::DIM_W;

    logic [bito_pkg::RANK-1:0][DW-1:0] fac;
    logic [DW-1:0]     str2_reg;
    logic [2*DW-1:0]   str1_reg;
    logic [OW-1:0]     str0_reg;
    logic [OW-1:0]     str [bito_pkg::RANK];
    logic [OW-1:0]     prod_reg [bito_pkg::RANK];
    logic [OW-1:0]     sum_reg, off_reg;
    bito_pkg::crd_vec_t crd_a_reg, crd_b_reg, crd_c_reg;
    logic [2:0]        vld_reg;

    // broadcast or empty dimensions do not scale the stride
    always_comb begin
        for (int d = 0; d < bito_pkg::RANK; d++) begin
            fac[d] = (bmask[d] || sizes[d] == '0) ? DW'(1) : sizes[d];
        end
    end

    // strides are registered from the size registers, str0 by way of str1_reg
    always_ff @(posedge aclk) begin
        str2_reg <= fac[3];
        str1_reg <= (2*DW)'(fac[3]) * (2*DW)'(fac[2]);
        str0_reg <= OW'((3*DW)'(str1_reg) * (3*DW)'(fac[1]));
    end

    assign str[3] = OW'(1);
    assign str[2] = OW'(str2_reg);
    assign str[1] = OW'(str1_reg);
    assign str[0] = str0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int d = 0; d < bito_pkg::RANK; d++) begin
                prod_reg[d] <= bmask[d] ? '0 : OW'(in_crd[d]) * str[d];
            end
            crd_a_reg <= in_crd;
            sum_reg   <= prod_reg[0] + prod_reg[1] + prod_reg[2] + prod_reg[3];
            crd_b_reg <= crd_a_reg;
            off_reg   <= sum_reg * OW'(ebytes);
            crd_c_reg <= crd_b_reg;
        end
    end

    assign out_vld      = vld_reg[2];
    assign out_word.off = off_reg;
    assign out_word.crd = crd_c_reg;

endmodule

`default_nettype wire

// File: rtl/bito_skid.sv
// ----------------------------------------------------------------------------
// bito_skid
// Two-word output buffer; room is derived combinationally from the registered fill count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "broadcast_index_to_offset_top_defines.svh"

module bito_skid (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                push,
    input  wire bito_pkg::out_word_t in_word,
    output logic                     room,
    output logic                     m_valid,
    output bito_pkg::out_word_t      m_word,
    input  wire logic                m_ready
);

    bito_pkg::out_word_t mem_reg [2];
    logic [1:0]          cnt_reg, cnt_next;
    logic                wr_reg, rd_reg;
    logic                pop;

    assign room    = (cnt_reg != 2'd2);
    assign m_valid = (cnt_reg != 2'd0);
    assign m_word  = mem_reg[rd_reg];
    assign pop     = m_valid && m_ready;

    always_comb begin
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) begin
                wr_reg <= !wr_reg;
            end
            if (pop) begin
                rd_reg <= !rd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_reg] <= in_word;
        end
    end

    `BITO_AST_IMM(a_no_push_full, cnt_reg == 2'd2, !push, "word pushed into full buffer")
    `BITO_AST_NXT(a_full_hold, cnt_reg == 2'd2 && !m_ready, cnt_reg == 2'd2, "full buffer lost a word")
    `BITO_AST_NXT(a_drain, cnt_reg == 2'd1 && m_ready && !push, cnt_reg == 2'd0, "buffer failed to drain")

endmodule

`default_nettype wire

// File: rtl/broadcast_index_to_offset_top.sv
// ----------------------------------------------------------------------------
// broadcast_index_to_offset_top
// Unravel a flat output index into 4-D coords and a broadcast byte offset.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one word per linear index, s_tdata[31:0] = linear_index.
//   m_ channel: one word per index; m_tdata from bit 0 up holds coord0,
//     coord1, coord2, coord3 (16 bits each), byte_offset (35 bits), zero pad.
//   APB port: sizes, broadcast mask and element size at byte addresses 4*i.
//     Write only while the block is idle.
// Pipeline: 4 dividers of 32 one-bit stages, 3 ravel stages, output buffer.
// Throughput: one word per cycle while the output buffer has room; every divider
//   stage is a register stage and the whole pipeline advances together.
// Stall: the pipeline freezes when the two-word output buffer is full;
//   s_tready is taken from the buffer count only, so nothing is dropped.
// Reset: aresetn low clears all valid bits and the buffer, and sets the
//   sizes and element size to 1 and the broadcast mask to 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module broadcast_index_to_offset_top (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input words
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [bito_pkg::IDX_W-1:0]      s_tdata,   // linear_index
    // result words
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [bito_pkg::TDATA_W-1:0]         m_tdata,   // coord0..coord3, byte_offset
    // config
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [bito_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);

    localparam int RANK = bito_pkg::RANK;

    logic [RANK-1:0][bito_pkg::DIM_W-1:0] size_reg;
    logic [RANK-1:0]                      bmask_reg;
    logic [bito_pkg::EB_W-1:0]            eb_reg;
    logic                                 wr_en;
    logic                                 adv;

    // divider chain: index u feeds unit u, which handles dim RANK-1-u
    logic                          st_vld [RANK+1];
    logic [bito_pkg::IDX_W-1:0]    st_num [RANK+1];
    bito_pkg::crd_vec_t            st_crd [RANK+1];
    logic [bito_pkg::IDX_W-1:0]    o_quo  [RANK];
    logic [bito_pkg::DIM_W-1:0]    o_rem  [RANK];
    bito_pkg::crd_vec_t            o_crd  [RANK];
    logic                          o_vld  [RANK];

    logic                          rav_vld;
    bito_pkg::out_word_t           rav_word;
    bito_pkg::out_word_t           m_word;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int d = 0; d < RANK; d++) begin
                size_reg[d] <= bito_pkg::DIM_W'(1);
            end
            bmask_reg <= '0;
            eb_reg    <= bito_pkg::EB_W'(1);
        end else if (wr_en) begin
            case (paddr[4:2])
                bito_pkg::REG_SIZE0:  size_reg[0] <= pwdata[bito_pkg::DIM_W-1:0];
                bito_pkg::REG_SIZE1:  size_reg[1] <= pwdata[bito_pkg::DIM_W-1:0];
                bito_pkg::REG_SIZE2:  size_reg[2] <= pwdata[bito_pkg::DIM_W-1:0];
                bito_pkg::REG_SIZE3:  size_reg[3] <= pwdata[bito_pkg::DIM_W-1:0];
                bito_pkg::REG_BMASK:  bmask_reg   <= pwdata[RANK-1:0];
                bito_pkg::REG_EBYTES: eb_reg      <= pwdata[bito_pkg::EB_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            bito_pkg::REG_SIZE0:  prdata = 32'(size_reg[0]);
            bito_pkg::REG_SIZE1:  prdata = 32'(size_reg[1]);
            bito_pkg::REG_SIZE2:  prdata = 32'(size_reg[2]);
            bito_pkg::REG_SIZE3:  prdata = 32'(size_reg[3]);
            bito_pkg::REG_BMASK:  prdata = 32'(bmask_reg);
            bito_pkg::REG_EBYTES: prdata = 32'(eb_reg);
            default:              prdata = '0;
        endcase
    end

    // ---------------- pipeline ----------------
    // whole pipeline moves whenever the output buffer has a free slot
    assign s_tready = adv;

    always_comb begin
        st_vld[0] = s_tvalid;
        st_num[0] = s_tdata;
        st_crd[0] = '0;
        for (int u = 0; u < RANK; u++) begin
            st_vld[u+1]               = o_vld[u];
            st_num[u+1]               = o_quo[u];
            st_crd[u+1]               = o_crd[u];
            st_crd[u+1][RANK-1-u]     = o_rem[u];
        end
    end

    for (genvar u = 0; u < RANK; u++) begin : g_div
        bito_div_unit u_div (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .in_vld  (st_vld[u]),
            .in_num  (st_num[u]),
            .in_crd  (st_crd[u]),
            .dvsr    (size_reg[RANK-1-u]),
            .out_vld (o_vld[u]),
            .out_quo (o_quo[u]),
            .out_rem (o_rem[u]),
            .out_crd (o_crd[u])
        );
    end

    // quotient left after the outermost divide is dropped: index wraps
    bito_ravel u_ravel (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (adv),
        .in_vld   (st_vld[RANK]),
        .in_crd   (st_crd[RANK]),
        .sizes    (size_reg),
        .bmask    (bmask_reg),
        .ebytes   (eb_reg),
        .out_vld  (rav_vld),
        .out_word (rav_word)
    );

    bito_skid u_skid (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (rav_vld && adv),
        .in_word (rav_word),
        .room    (adv),
        .m_valid (m_tvalid),
        .m_word  (m_word),
        .m_ready (m_tready)
    );

    assign m_tdata = {{bito_pkg::PAD_W{1'b0}}, m_word.off, m_word.crd};

endmodule

`default_nettype wire

// File: test/bito_checker.sv
// ----------------------------------------------------------------------------
// bito_checker
// Follows register writes, predicts the coords and byte offset of every
// accepted index, and compares each result word field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bito_checker
    import bito_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    input  logic               s_tready,
    input  logic [IDX_W-1:0]   s_tdata,   // linear_index
    input  logic               m_tvalid,
    input  logic               m_tready,
    input  logic [TDATA_W-1:0] m_tdata,   // coord0..coord3, byte_offset, pad
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic               pready,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output int                 errors,
    output int                 pending,
    output int                 words_seen
);

    logic [DIM_W-1:0] dim_size [RANK];
    logic [3:0]       bcast_bits;
    logic [EB_W-1:0]  elem_bytes;
    out_word_t        expected_words [$];

    function automatic out_word_t predict_word(input logic [IDX_W-1:0] idx);
        logic [63:0] rest, sz, elem, stride, prod;
        out_word_t   w;
        rest   = 64'(idx);
        elem   = 0;
        stride = 1;
        for (int d = RANK - 1; d >= 0; d--) begin
            sz = (dim_size[d] == 0) ? 64'd1 : 64'(dim_size[d]);
            w.crd[d] = DIM_W'(rest % sz);
            rest = rest / sz;
        end
        for (int d = RANK - 1; d >= 0; d--) begin
            sz = (dim_size[d] == 0) ? 64'd1 : 64'(dim_size[d]);
            // broadcast or unit dims leave both offset and stride alone
            if (!bcast_bits[d] && sz != 1) begin
                elem   = elem + 64'(w.crd[d]) * stride;
                stride = stride * sz;
            end
        end
        prod  = elem * 64'(elem_bytes);
        w.off = prod[OFF_W-1:0];
        return w;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        errors++;
    endtask

    assign pending = expected_words.size();

    initial begin
        errors = 0;
        words_seen = 0;
    end

    always @(posedge aclk) begin
        out_word_t got, want;
        if (!aresetn) begin
            for (int d = 0; d < RANK; d++) dim_size[d] <= 1;
            bcast_bits <= 0;
            elem_bytes <= 1;
            expected_words.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_SIZE0:  dim_size[0] <= pwdata[DIM_W-1:0];
                    REG_SIZE1:  dim_size[1] <= pwdata[DIM_W-1:0];
                    REG_SIZE2:  dim_size[2] <= pwdata[DIM_W-1:0];
                    REG_SIZE3:  dim_size[3] <= pwdata[DIM_W-1:0];
                    REG_BMASK:  bcast_bits  <= pwdata[3:0];
                    REG_EBYTES: elem_bytes  <= pwdata[EB_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready) begin
                got = out_word_t'(m_tdata[RANK*DIM_W+OFF_W-1:0]);
                words_seen++;
                if (expected_words.size() == 0) begin
                    note_mismatch("unexpected word", 64'(got), 0);
                end else begin
                    want = expected_words.pop_front();
                    for (int d = 0; d < RANK; d++)
                        if (got.crd[d] !== want.crd[d])
                            note_mismatch($sformatf("coord%0d", d), got.crd[d], want.crd[d]);
                    if (got.off !== want.off)
                        note_mismatch("byte_offset", got.off, want.off);
                end
            end
            if (s_tvalid && s_tready)
                expected_words.push_back(predict_word(s_tdata));
        end
    end

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives linear indices and register settings into the broadcast address
// generator with random idling on both channels; the checker judges results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import bito_pkg::*;

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_tvalid = 0;
    logic               s_tready;
    logic [IDX_W-1:0]   s_tdata = 0;     // linear_index
    logic               m_tvalid;
    logic               m_tready = 0;
    logic [TDATA_W-1:0] m_tdata;         // coord0..coord3, byte_offset, pad
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0]  paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    int  errors, pending, words_seen;
    int  indices_sent = 0;
    bit  idle_on = 1;                    // random gaps/stalls enabled
    int  stall_left = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    broadcast_index_to_offset_top uut (.*);

    bito_checker chk (.*);

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #400000;
        $display("[broadcast_index_to_offset_top] ERROR");
        $finish;
    end

    // Receiver: random stall bursts, plenty of open stretches.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 16);
            m_tready   <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    // Register write: setup phase, then access; lands at the access edge, then the bus idles.
    task automatic reg_write(input int idx, input logic [31:0] val);
        logic rdy;
        psel    <= 1;
        penable <= 0;
        pwrite  <= 1;
        paddr   <= ADDR_W'(idx * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1;
        do begin
            @(negedge aclk);
            rdy = pready;
            @(posedge aclk);
        end while (!rdy);
        psel    <= 0;
        penable <= 0;
        pwrite  <= 0;
        @(posedge aclk);
    endtask

    task automatic set_shape(input logic [15:0] d0, d1, d2, d3,
                             input logic [3:0] mask, input logic [3:0] eb);
        reg_write(REG_SIZE0, {16'hdead, d0});
        reg_write(REG_SIZE1, 32'(d1));
        reg_write(REG_SIZE2, 32'(d2));
        reg_write(REG_SIZE3, 32'(d3));
        reg_write(REG_BMASK, {28'hfffffff, mask});
        reg_write(REG_EBYTES, 32'(eb));
    endtask

    // One input word; optional gap first, then hold valid until taken.
    task automatic send_index(input logic [31:0] idx);
        logic rdy;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= idx;
        do begin
            @(negedge aclk);
            rdy = s_tready;
            @(posedge aclk);
        end while (!rdy);
        indices_sent++;
    endtask

    // Registers only change with the pipeline empty.
    task automatic drain;
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    function automatic logic [15:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 16'hffff;
            1:       return 16'(0);                  // zero reads as one
            2:       return 16'($urandom);
            default: return 16'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic random_burst(input int n, input longint span);
        for (int i = 0; i < n; i++) begin
            // mostly inside twice the volume, some full-range wrap cases
            if (span > 0 && span < 64'h80000000 && $urandom_range(0, 3) != 0)
                send_index(32'($urandom) % 32'(span * 2));
            else
                send_index($urandom);
        end
    endtask

    initial begin
        logic [15:0] d0, d1, d2, d3;
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // Defaults after reset: every size 1, so all coords and offsets 0.
        send_index(0);
        send_index(32'hffffffff);
        drain();

        // Small shape, mixed broadcast, element size 8; wrap past the volume.
        set_shape(2, 3, 4, 5, 4'b0101, 8);
        send_index(0);
        send_index(1);
        send_index(119);
        send_index(120);
        send_index(32'hffffffff);
        send_index(32'h80000000);
        drain();

        // All dims full width, nothing broadcast, largest element size:
        // offset overflows 35 bits.
        set_shape(16'hffff, 16'hffff, 16'hffff, 16'hffff, 4'b0000, 15);
        send_index(32'hffffffff);
        send_index(32'h7fffffff);
        send_index(32'h00010000);
        drain();

        // Zero sizes, full broadcast, zero element size.
        set_shape(0, 7, 0, 9, 4'b1111, 0);
        send_index(62);
        send_index(63);
        send_index(32'hffffffff);
        drain();
        set_shape(0, 7, 0, 9, 4'b0000, 1);
        send_index(62);
        send_index(32'hfffffffe);
        // unmapped register slots must not disturb anything
        drain();
        reg_write(6, 32'h0);
        reg_write(7, 32'hffffffff);
        send_index(62);
        send_index(32'hfffffffe);
        drain();

        // Random phases: shapes, masks and element sizes vary each time.
        for (int ph = 0; ph < 8; ph++) begin
            d0 = pick_size(); d1 = pick_size(); d2 = pick_size(); d3 = pick_size();
            set_shape(d0, d1, d2, d3, 4'($urandom), 4'($urandom_range(0, 15)));
            if (ph == 7) idle_on = 0;    // closing stretch runs flat out
            random_burst(54, longint'(d0 == 0 ? 1 : d0) * (d1 == 0 ? 1 : d1)
                             * (d2 == 0 ? 1 : d2) * (d3 == 0 ? 1 : d3));
            drain();
        end

        repeat (140) @(posedge aclk);
        $display("covered %0d indices over reset defaults and 12 shapes; %0d words checked",
                 indices_sent, words_seen);
        $display("wrap, zero sizes, broadcast masks, element sizes 0..15 and idle gaps included");
        if (errors == 0 && pending == 0) begin
            $display("[broadcast_index_to_offset_top] OK");
        end else begin
            $display("[broadcast_index_to_offset_top] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl
rtl/bito_pkg.sv
rtl/bito_div_unit.sv
rtl/bito_ravel.sv
rtl/bito_skid.sv
rtl/broadcast_index_to_offset_top.sv
test/bito_checker.sv
test/tb_top.sv
